>>> hw/rtl/ffsd_pkg.sv
package ffsd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 14;
   localparam int unsigned FRAME_LEN  = 5;
   localparam int unsigned COUNT_W    = 3;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam byte_type  HDR_BYTE   = 8'h5A;
   localparam byte_type  TRL_BYTE   = 8'hA5;
   localparam count_type CNT_HUNT   = 3'd0;
   localparam count_type CNT_BYTE1  = 3'd1;
   localparam count_type CNT_BYTE2  = 3'd2;
   localparam count_type CNT_BYTE3  = 3'd3;
   localparam count_type CNT_LAST   = count_type'(FRAME_LEN - 1);

endpackage

>>> hw/rtl/ffsd_if.sv
interface ffsd_req_if;
   import ffsd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffsd_rsp_if;
   import ffsd_pkg::*;

   logic     valid;
   logic     ready;
   pos_type  encoder_position;
   logic     start_switch;
   logic     end_switch;
   byte_type speed_raw;

   modport source (output valid, output encoder_position, output start_switch,
                   output end_switch, output speed_raw, input ready);
   modport sink   (input valid, input encoder_position, input start_switch,
                   input end_switch, input speed_raw, output ready);
endinterface

>>> hw/rtl/fixed_frame_sensor_deframer_core.sv
// channel   | dir | handshake     | word
// ----------+-----+---------------+------------------------------------------------------
// req_port  | in  | valid / ready | rx_byte
// rsp_port  | out | valid / ready | encoder_position, start_switch, end_switch, speed_raw
//
// One word accepted per cycle while the result is not stalled; the closing word passes through
// the input register, then the result register, before the result is valid.
// Reset (synchronous, active high) clears the input and result valids and the byte count.
// A stalled result holds the input register; req_port drops ready once that register is full.
module fixed_frame_sensor_deframer_core (
   input  logic              clock,
   input  logic              reset,
   ffsd_req_if.sink          req_port,
   ffsd_rsp_if.source        rsp_port
);
   import ffsd_pkg::*;

   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;
   count_type byte_count_ff, byte_count_in;
   byte_type  byte1_ff, byte2_ff, byte3_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   pos_type   pos_ff;
   logic      start_ff, end_ff;
   byte_type  speed_ff;
   logic      advance;
   logic      emit;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_port.valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_comb begin
      byte_count_in = byte_count_ff;
      emit          = 1'b0;
      if (advance) begin
         if (byte_count_ff == CNT_HUNT) begin
            if (in_byte_ff == HDR_BYTE) begin
               byte_count_in = CNT_BYTE1;
            end
         end else if (byte_count_ff == CNT_LAST) begin
            byte_count_in = CNT_HUNT;
            emit          = (in_byte_ff == TRL_BYTE);
         end else if (in_byte_ff == TRL_BYTE) begin
            byte_count_in = CNT_HUNT;
         end else begin
            byte_count_in = byte_count_ff + CNT_BYTE1;
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         byte_count_ff <= CNT_HUNT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         byte_count_ff <= byte_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.ready && req_port.valid) begin
         in_byte_ff <= req_port.rx_byte;
      end
      if (advance) begin
         unique case (byte_count_ff)
            CNT_BYTE1: byte1_ff <= in_byte_ff;
            CNT_BYTE2: byte2_ff <= in_byte_ff;
            CNT_BYTE3: byte3_ff <= in_byte_ff;
            default: ;
         endcase
      end
      if (emit) begin
         pos_ff   <= {byte1_ff, byte2_ff[BYTE_W-1:2]};
         start_ff <= byte2_ff[0];
         end_ff   <= byte2_ff[1];
         speed_ff <= byte3_ff;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.encoder_position = pos_ff;
   assign rsp_port.start_switch     = start_ff;
   assign rsp_port.end_switch       = end_ff;
   assign rsp_port.speed_raw        = speed_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_LAST)
      else $error("byte count beyond frame length");

   a_rise_needs_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result without a processed word");

   a_emit_returns_hunt: assert property (@(posedge clock) disable iff (reset)
      emit |=> byte_count_ff == CNT_HUNT)
      else $error("frame not closed after result");

   a_no_advance_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready) |-> !emit)
      else $error("result overwritten while stalled");
`endif

endmodule

>>> tb/fixed_frame_sensor_deframer_core_test.sv
module fixed_frame_sensor_deframer_core_test;
   import ffsd_pkg::*;

   localparam int unsigned WORD_TARGET = 1900;

   typedef struct packed {
      pos_type  encoder_position;
      logic     start_switch;
      logic     end_switch;
      byte_type speed_raw;
   } reading_type;

   class deframe_scoreboard_type;
      bit          in_frame = 1'b0;
      count_type   byte_count = CNT_HUNT;
      byte_type    frame_bytes [FRAME_LEN];
      reading_type expected_readings [$];
      int unsigned mismatches = 0;
      int unsigned readings_checked = 0;
      int unsigned frames_dropped = 0;

      function int unsigned pending();
         return expected_readings.size();
      endfunction

      // returns 1 when the word is taken into a frame, 0 when hunting skips it
      function bit note_byte(byte_type b);
         reading_type r;
         if (!in_frame) begin
            if (b != HDR_BYTE)
               return 1'b0;
            in_frame = 1'b1;
            byte_count = CNT_HUNT;
         end
         frame_bytes[byte_count] = b;
         if (byte_count != CNT_LAST) begin
            byte_count = byte_count + CNT_BYTE1;
            if (b == TRL_BYTE) begin
               in_frame = 1'b0;
               byte_count = CNT_HUNT;
               frames_dropped++;
            end
            return 1'b1;
         end
         in_frame = 1'b0;
         byte_count = CNT_HUNT;
         if (b != TRL_BYTE) begin
            frames_dropped++;
            return 1'b1;
         end
         r.encoder_position = {frame_bytes[CNT_BYTE1], 6'b000000}
                              + pos_type'(frame_bytes[CNT_BYTE2] >> 2);
         r.start_switch  = frame_bytes[CNT_BYTE2][0];
         r.end_switch    = frame_bytes[CNT_BYTE2][1];
         r.speed_raw     = frame_bytes[CNT_BYTE3];
         expected_readings.push_back(r);
         return 1'b1;
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            $error("unexpected reading: position %0d speed %0d",
                   got.encoder_position, got.speed_raw);
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         readings_checked++;
         if (got.encoder_position !== want.encoder_position) begin
            $error("encoder_position: expected %0d, got %0d",
                   want.encoder_position, got.encoder_position);
            mismatches++;
         end
         if (got.start_switch !== want.start_switch) begin
            $error("start_switch: expected %0d, got %0d",
                   want.start_switch, got.start_switch);
            mismatches++;
         end
         if (got.end_switch !== want.end_switch) begin
            $error("end_switch: expected %0d, got %0d",
                   want.end_switch, got.end_switch);
            mismatches++;
         end
         if (got.speed_raw !== want.speed_raw) begin
            $error("speed_raw: expected %0d, got %0d",
                   want.speed_raw, got.speed_raw);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ffsd_req_if req_bus ();
   ffsd_rsp_if rsp_bus ();

   fixed_frame_sensor_deframer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   deframe_scoreboard_type sb = new;

   int unsigned words_used = 0;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned stall_cycle = 0;
   int unsigned stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 96 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= (stall_cycle % 4 == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      reading_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.encoder_position = rsp_bus.encoder_position;
         got.start_switch     = rsp_bus.start_switch;
         got.end_switch       = rsp_bus.end_switch;
         got.speed_raw        = rsp_bus.speed_raw;
         sb.check_reading(got);
      end
   end

   function automatic byte_type pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return HDR_BYTE;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic byte_type data_byte();
      byte_type b;
      do
         b = pick_byte();
      while (b == TRL_BYTE);
      return b;
   endfunction

   // call at a falling edge; returns at a falling edge with valid still high
   task automatic send_byte(input byte_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(50, 200);
         else
            burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do
         @(posedge clock);
      while (!(req_bus.valid && req_bus.ready));
      if (sb.note_byte(b))
         words_used++;
      words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_frame(input byte_type b1, input byte_type b2,
                             input byte_type b3, input byte_type last);
      send_byte(HDR_BYTE);
      send_byte(b1);
      send_byte(b2);
      send_byte(b3);
      send_byte(last);
   endtask

   initial begin
      int unsigned kind;
      int unsigned cut;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h00, 8'h00, 8'h00, TRL_BYTE);
      send_frame(8'hFF, 8'hFF, 8'hFF, TRL_BYTE);
      send_frame(HDR_BYTE, HDR_BYTE, HDR_BYTE, TRL_BYTE);
      send_byte(HDR_BYTE);
      send_byte(8'h12);
      send_byte(TRL_BYTE);
      send_frame(8'h11, 8'h22, 8'h33, HDR_BYTE);

      while (words_used < WORD_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            send_frame(data_byte(), data_byte(), data_byte(), TRL_BYTE);
         end else if (kind == 7) begin
            send_byte(byte_type'($urandom_range(0, 255)));
         end else if (kind == 8) begin
            cut = $urandom_range(1, 3);
            send_byte(HDR_BYTE);
            repeat (cut - 1) send_byte(data_byte());
            send_byte(TRL_BYTE);
         end else begin
            send_frame(data_byte(), data_byte(), data_byte(),
                       $urandom_range(0, 1) ? HDR_BYTE : data_byte());
         end
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d readings never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("sent %0d words (%0d inside frames), checked %0d readings, dropped %0d frames",
               words_sent, words_used, sb.readings_checked, sb.frames_dropped);
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
